[hdl/packet_ack_rtt_loss_tracker_assert.svh]
// Assertion macros shared by the tracker checker.
// No dependencies.
`ifndef PACKET_ACK_RTT_LOSS_TRACKER_ASSERT_SVH
`define PACKET_ACK_RTT_LOSS_TRACKER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PALT_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PALT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[hdl/palt_pkg.sv]
// Shared types and constants for the acknowledgement tracker.
// No dependencies.
package palt_pkg;
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
    localparam int MASK_BITS  = 32;
    localparam int MASK_IDX   = $clog2(MASK_BITS + 1);
    localparam logic [31:0] RTT_LIMIT = 32'd2000;

    typedef enum logic [1:0] {
        K_SEND  = 2'd0,
        K_ACK   = 2'd1,
        K_QUERY = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == '1) ? v : v + 32'd1;
    endfunction
endpackage

[hdl/packet_ack_rtt_loss_tracker.sv]
// Packet acknowledgement tracker, top level.
// Channels: input transactions (kind, sequence, ack mask, time in ms) and
// one result transaction per input item, both with valid/ready handshake.
// The slot table (sequence, time, used/acked/lost marks) sits in one
// synchronous memory with a registered read port; every slot access for
// an item reads the slot and writes it back modified where it changes.
// A send or query passes through S_SIMPLE and S_OUT, and its result is
// registered as the block leaves S_OUT. An ack reads its own slot and the
// slot of each set mask bit and marks them acked where they match (a clear
// mask bit is stepped past without a read), then reads and updates all 64
// slots for the drop scan, then runs a restoring divider for the loss
// fraction. One item is in the block at a time.
// After reset a clearing pass writes every slot empty, during which no
// input transaction is accepted.
// A result waits in the output register while the receiver stalls; the
// next input item is taken as soon as the block is free again, but it is
// not finished until the earlier result has been taken.
module packet_ack_rtt_loss_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_ack_mask,
    input  logic [31:0] i_time_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_acked,
    output logic [18:0] o_rtt_q8,
    output logic [31:0] o_sent_total,
    output logic [31:0] o_acked_total,
    output logic [31:0] o_dropped_total,
    output logic [16:0] o_loss_q16
);
    import palt_pkg::*;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] tm;
        logic        used;
        logic        acked;
        logic        lost;
    } t_slot;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_SIMPLE = 9'b000000100,
        S_ARD    = 9'b000001000,
        S_AUPD   = 9'b000010000,
        S_DRD    = 9'b000100000,
        S_DUPD   = 9'b001000000,
        S_DIV    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    // Slot memory.
    t_slot                 r_mem [SLOT_COUNT];
    t_slot                 r_rd;
    logic                  mem_we;
    logic [SLOT_BITS-1:0]  mem_wa;
    logic [SLOT_BITS-1:0]  mem_ra;
    t_slot                 mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    t_state                r_state, n_state;
    logic [SLOT_BITS:0]    r_cnt, n_cnt;
    logic [MASK_IDX-1:0]   r_mi, n_mi;
    logic [1:0]            r_kind;
    logic [31:0]           r_seq, r_mask, r_now;
    logic [31:0]           r_aseq, n_aseq;
    logic [18:0]           r_rtt, n_rtt;
    logic [31:0]           r_sends, n_sends, r_acks, n_acks, r_drops, n_drops;
    logic [16:0]           r_loss, n_loss;
    logic [32:0]           r_den, n_den;
    logic [33:0]           r_rem, n_rem;
    logic [16:0]           r_quo, n_quo;
    logic                  r_hit, n_hit;
    logic                  r_ovalid, n_ovalid;
    logic                  r_out_hit;
    logic [18:0]           r_out_rtt;
    logic [31:0]           r_out_sends, r_out_acks, r_out_drops;
    logic [16:0]           r_out_loss;
    logic [33:0]           sub;
    logic [31:0]           sample, behind;
    logic [21:0]           rtt_sum;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_is_acked = r_out_hit;
    assign o_rtt_q8 = r_out_rtt;
    assign o_sent_total = r_out_sends;
    assign o_acked_total = r_out_acks;
    assign o_dropped_total = r_out_drops;
    assign o_loss_q16 = r_out_loss;

    assign sample  = r_now - r_rd.tm;
    assign rtt_sum = {r_rtt, 3'b000} - {3'b000, r_rtt} + {sample[13:0], 8'h00};
    assign behind  = r_seq - (r_rd.seq + 32'(MASK_BITS));
    assign sub     = r_rem - {1'b0, r_den};

    // Sequencer: clearing pass, then per item slot reads and write-backs, drop scan, division and output.
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_mi = r_mi; n_aseq = r_aseq;
        n_rtt = r_rtt; n_sends = r_sends; n_acks = r_acks; n_drops = r_drops;
        n_loss = r_loss; n_den = r_den; n_rem = r_rem; n_quo = r_quo;
        n_hit = r_hit; n_ovalid = r_ovalid;
        mem_we = 1'b0; mem_wa = r_aseq[SLOT_BITS-1:0]; mem_wd = r_rd;
        mem_ra = r_aseq[SLOT_BITS-1:0];
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_cnt[SLOT_BITS-1:0];
                mem_wd = '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[SLOT_BITS-1:0] == SLOT_BITS'(SLOT_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_ra = i_seq_number[SLOT_BITS-1:0];
                if (i_valid) begin
                    n_aseq = i_seq_number;
                    n_mi = '0;
                    n_cnt = '0;
                    if (i_kind == K_ACK && i_seq_number != 32'd0) begin
                        n_state = S_ARD;
                    end else begin
                        n_state = S_SIMPLE;
                    end
                end
            end
            S_SIMPLE: begin
                n_hit = 1'b0;
                if (r_kind == K_SEND) begin
                    mem_we = 1'b1;
                    mem_wd = '{seq: r_seq, tm: r_now, used: 1'b1, acked: 1'b0,
                               lost: 1'b0};
                    n_sends = sat_inc(r_sends);
                end else if (r_kind == K_QUERY) begin
                    n_hit = r_rd.used && r_rd.acked && (r_rd.seq == r_seq);
                end
                n_state = S_OUT;
            end
            S_ARD: begin
                n_state = S_AUPD;
            end
            S_AUPD: begin
                // Mark this sequence acked if its slot holds it unacked.
                if (r_aseq != 32'd0 && r_rd.used && !r_rd.acked && r_rd.seq == r_aseq)
                begin
                    mem_we = 1'b1;
                    mem_wd.acked = 1'b1;
                    n_acks = sat_inc(r_acks);
                    if (sample != 32'd0 && sample < RTT_LIMIT) begin
                        n_rtt = rtt_sum[21:3];
                    end
                end
                n_state = S_ARD;
                if (r_mi == MASK_IDX'(MASK_BITS)) begin
                    n_state = S_DRD;
                    n_cnt = '0;
                end else if (!r_mask[r_mi[MASK_IDX-2:0]]) begin
                    n_state = S_AUPD;
                    n_mi = r_mi + 1'b1;
                    n_aseq = 32'd0;
                end else begin
                    n_mi = r_mi + 1'b1;
                    n_aseq = r_seq - 32'(r_mi) - 32'd1;
                end
                // A skipped mask bit simply advances in place.
                if (n_state == S_AUPD) begin
                    mem_we = mem_we;
                end
            end
            S_DRD: begin
                mem_ra = r_cnt[SLOT_BITS-1:0];
                n_state = S_DUPD;
            end
            S_DUPD: begin
                mem_wa = r_cnt[SLOT_BITS-1:0];
                if (r_rd.used && !r_rd.acked && !r_rd.lost &&
                    behind != 32'd0 && !behind[31]) begin
                    mem_we = 1'b1;
                    mem_wd.lost = 1'b1;
                    n_drops = sat_inc(r_drops);
                end
                n_cnt = r_cnt + 1'b1;
                n_state = S_DRD;
                if (r_cnt[SLOT_BITS-1:0] == SLOT_BITS'(SLOT_COUNT - 1)) begin
                    n_state = S_DIV;
                    n_den = {1'b0, r_acks} + {1'b0, n_drops};
                    if ({1'b0, r_acks} + {1'b0, n_drops} == 33'd0) begin
                        n_den = 33'd1;
                    end
                    n_rem = '0;
                    n_quo = '0;
                    n_cnt = '0;
                end
            end
            S_DIV: begin
                // Restoring division of drops * 2^16, one quotient bit a cycle.
                n_rem = {r_rem[32:0], (r_cnt == '0) ? 1'b0 : 1'b0};
                if (r_cnt == '0) begin
                    n_rem = {2'b00, r_drops};
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_rem = (sub[33]) ? r_rem : sub;
                    n_quo = {r_quo[15:0], ~sub[33]};
                    if (r_cnt == (SLOT_BITS+1)'(17)) begin
                        n_loss = {r_quo[15:0], ~sub[33]};
                        n_state = S_OUT;
                        n_hit = 1'b0;
                    end else begin
                        n_rem = (sub[33]) ? {r_rem[32:0], 1'b0} : {sub[32:0], 1'b0};
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                if (r_cnt == '0) begin
                    n_quo = '0;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_cnt <= '0; r_ovalid <= 1'b0;
            r_rtt <= '0; r_sends <= '0; r_acks <= '0; r_drops <= '0;
            r_loss <= '0; r_hit <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_ovalid <= n_ovalid;
            r_rtt <= n_rtt; r_sends <= n_sends; r_acks <= n_acks;
            r_drops <= n_drops; r_loss <= n_loss; r_hit <= n_hit;
        end
    end

    // Result registers: loaded as a finished item is handed to the receiver,
    // so a waiting result stays put while the next item is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_hit <= 1'b0; r_out_rtt <= '0; r_out_sends <= '0;
            r_out_acks <= '0; r_out_drops <= '0; r_out_loss <= '0;
        end else if (r_state == S_OUT && (!r_ovalid || i_ready)) begin
            r_out_hit <= r_hit; r_out_rtt <= r_rtt; r_out_sends <= r_sends;
            r_out_acks <= r_acks; r_out_drops <= r_drops; r_out_loss <= r_loss;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= i_kind; r_seq <= i_seq_number;
            r_mask <= i_ack_mask; r_now <= i_time_ms;
        end
        r_mi <= n_mi; r_aseq <= n_aseq; r_den <= n_den;
        r_rem <= n_rem; r_quo <= n_quo;
    end
endmodule

[hdl/palt_checker.sv]
// Port-level checker for the tracker, bound to the top level.
// Depends on packet_ack_rtt_loss_tracker_assert.svh.
`include "packet_ack_rtt_loss_tracker_assert.svh"
module palt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [16:0] o_loss_q16,
    input logic [31:0] o_sent_total
);
    `PALT_ASSERT_IMP(a_loss_range, i_clk, i_rst_n, o_valid, o_loss_q16 <= 17'd65536)
    `PALT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `PALT_ASSERT_NEXT(a_sent_mono, i_clk, i_rst_n, 1'b1, o_sent_total >= $past(o_sent_total))
    `PALT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
endmodule

bind packet_ack_rtt_loss_tracker palt_checker u_palt_checker (.*);
